@@ rtl/lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lcd_pkg
// shared types and constants of the lfu counter decay block
// ----------------------------------------------------------------------------
package lcd_pkg;

  // counter and quotient widths
  localparam int COUNT_W = 8;
  localparam int QUOT_W  = 9;   // eight quotient bits plus one saturation bit

  // number of division cells, one per quotient bit
  localparam int DIV_CELLS = QUOT_W;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int PERIOD_W   = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1;

  localparam logic [COUNT_W-1:0] SENTINEL_COUNTER = 8'd127;
  localparam logic [COUNT_W-1:0] PERIOD_CAP       = 8'd255;

  // per-item side data that travels along the cell chain
  typedef struct packed {
    logic               sentinel;
    logic [COUNT_W-1:0] counter;
    logic               last;
    logic [QUOT_W-1:0]  quot;
  } side_t;

endpackage

@@ rtl/lcd_if.sv @@
// ----------------------------------------------------------------------------
// lcd_if
// valid/ready channels carrying input and result items
// ----------------------------------------------------------------------------
interface lcd_in_if #(
  parameter int TIME_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [TIME_WIDTH-1:0]         last_access_time;
  logic [lcd_pkg::COUNT_W-1:0]   counter_in;
  logic [TIME_WIDTH-1:0]         now_time;
  logic                          last_in_batch;

  modport source (
    output valid, last_access_time, counter_in, now_time, last_in_batch,
    input  ready
  );
  modport sink (
    input  valid, last_access_time, counter_in, now_time, last_in_batch,
    output ready
  );
endinterface

interface lcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcd_pkg::COUNT_W-1:0]   counter_out;
  logic                          last_out;

  modport source (
    output valid, counter_out, last_out,
    input  ready
  );
  modport sink (
    input  valid, counter_out, last_out,
    output ready
  );
endinterface

@@ rtl/lfu_counter_decay_core.sv @@
// pipeline: an accepted item passes the registered entry stage, nine
//   division cells and output stage before its result is valid
// throughput: one item per cycle; the whole chain advances together and
//   holds only while a valid result waits at the output
// reset: synchronous, active high; clears all valid flags and sets the
//   decay period to 1, no clearing pass
// ----------------------------------------------------------------------------
// lfu_counter_decay_core
// ages an lfu counter by whole decay periods elapsed since last access
// ----------------------------------------------------------------------------
module lfu_counter_decay_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  lcd_in_if.sink                         in_ch,
  lcd_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lcd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lcd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int NCELL = lcd_pkg::DIV_CELLS;

  // configuration register and its effective divisor (zero acts as one)
  logic [lcd_pkg::PERIOD_W-1:0] decay_period;
  logic [lcd_pkg::PERIOD_W-1:0] divisor;
  logic                         cfg_write;

  // chain stage 0 is the entry stage, stage k+1 is after division cell k
  logic                  valid_c [NCELL+1];
  lcd_pkg::side_t        side_c  [NCELL+1];
  logic [TIME_WIDTH-1:0] rem_c   [NCELL+1];

  logic en;

  // only one register, so the byte address within the word is ignored
  assign cfg_write = psel && penable && pwrite && (paddr[lcd_pkg::CFG_ADDR_W-1:0] == paddr);
  assign pready    = 1'b1;
  assign prdata    = decay_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_period <= lcd_pkg::PERIOD_RESET;
      divisor      <= lcd_pkg::PERIOD_RESET;
    end else if (cfg_write) begin
      decay_period <= pwdata;
      divisor      <= (pwdata == '0) ? lcd_pkg::PERIOD_RESET : pwdata;
    end
  end

  // whole chain advances unless a result is stalled at the output register
  assign en           = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en;

  // entry stage: elapsed time, sentinel flag
  lcd_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .valid_i          (in_ch.valid),
    .last_access_time (in_ch.last_access_time),
    .counter_in       (in_ch.counter_in),
    .now_time         (in_ch.now_time),
    .last_in_batch    (in_ch.last_in_batch),
    .valid_o          (valid_c[0]),
    .side_o           (side_c[0]),
    .rem_o            (rem_c[0])
  );

  // division cells, most significant quotient bit first; the top bit
  // flags a period count of 256 or more, which saturates
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    lcd_div_cell #(
      .TIME_WIDTH (TIME_WIDTH),
      .SHIFT      (NCELL - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (divisor),
      .valid_i (valid_c[k]),
      .side_i  (side_c[k]),
      .rem_i   (rem_c[k]),
      .valid_o (valid_c[k+1]),
      .side_o  (side_c[k+1]),
      .rem_o   (rem_c[k+1])
    );
  end

  // output stage: saturate, subtract with clamp at zero, sentinel value
  lcd_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .valid_i     (valid_c[NCELL]),
    .side_i      (side_c[NCELL]),
    .valid_o     (out_ch.valid),
    .counter_out (out_ch.counter_out),
    .last_out    (out_ch.last_out)
  );

endmodule

@@ rtl/lcd_front.sv @@
// ----------------------------------------------------------------------------
// lcd_front
// entry stage: elapsed time and sentinel detection
// ----------------------------------------------------------------------------
module lcd_front #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic [TIME_WIDTH-1:0]       last_access_time,
  input  logic [lcd_pkg::COUNT_W-1:0] counter_in,
  input  logic [TIME_WIDTH-1:0]       now_time,
  input  logic                        last_in_batch,
  output logic                        valid_o,
  output lcd_pkg::side_t              side_o,
  output logic [TIME_WIDTH-1:0]       rem_o
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  // elapsed wraps modulo 2^TIME_WIDTH
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o           <= now_time - last_access_time;
      side_o.sentinel <= &last_access_time;
      side_o.counter  <= counter_in;
      side_o.last     <= last_in_batch;
      side_o.quot     <= '0;
    end
  end

endmodule

@@ rtl/lcd_div_cell.sv @@
// ----------------------------------------------------------------------------
// lcd_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
module lcd_div_cell #(
  parameter int TIME_WIDTH = 32,
  parameter int SHIFT      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [lcd_pkg::PERIOD_W-1:0] divisor,
  input  logic                         valid_i,
  input  lcd_pkg::side_t               side_i,
  input  logic [TIME_WIDTH-1:0]        rem_i,
  output logic                         valid_o,
  output lcd_pkg::side_t               side_o,
  output logic [TIME_WIDTH-1:0]        rem_o
);

  localparam int MAX_W = (TIME_WIDTH > lcd_pkg::PERIOD_W) ? TIME_WIDTH : lcd_pkg::PERIOD_W;
  localparam int CMP_W = MAX_W + lcd_pkg::QUOT_W;

  logic [CMP_W-1:0]      shifted;
  logic [CMP_W-1:0]      rem_wide;
  logic                  ge;
  logic [TIME_WIDTH-1:0] rem_next;

  always_comb begin
    shifted  = CMP_W'(divisor) << SHIFT;
    rem_wide = CMP_W'(rem_i);
    ge       = rem_wide >= shifted;
    // when ge holds the shifted divisor fits in TIME_WIDTH bits
    rem_next = ge ? (rem_i - shifted[TIME_WIDTH-1:0]) : rem_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o           <= rem_next;
      side_o.sentinel <= side_i.sentinel;
      side_o.counter  <= side_i.counter;
      side_o.last     <= side_i.last;
      side_o.quot     <= {side_i.quot[lcd_pkg::QUOT_W-2:0], ge};
    end
  end

endmodule

@@ rtl/lcd_finish.sv @@
// ----------------------------------------------------------------------------
// lcd_finish
// saturate period count, subtract with clamp, sentinel select
// ----------------------------------------------------------------------------
module lcd_finish (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_i,
  input  lcd_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [lcd_pkg::COUNT_W-1:0] counter_out,
  output logic                        last_out
);

  logic [lcd_pkg::COUNT_W-1:0] periods;
  logic [lcd_pkg::COUNT_W-1:0] result;

  always_comb begin
    periods = side_i.quot[lcd_pkg::QUOT_W-1] ? lcd_pkg::PERIOD_CAP
                                             : side_i.quot[lcd_pkg::COUNT_W-1:0];
    if (side_i.sentinel) begin
      result = lcd_pkg::SENTINEL_COUNTER;
    end else if (periods > side_i.counter) begin
      result = '0;
    end else begin
      result = side_i.counter - periods;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      counter_out <= result;
      last_out    <= side_i.last;
    end
  end

endmodule

@@ rtl/lcd_checker.sv @@
// ----------------------------------------------------------------------------
// lcd_checker
// port-level checks of the lfu counter decay block
// ----------------------------------------------------------------------------
module lcd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lcd_pkg::COUNT_W-1:0]    counter_out,
  input logic                           last_out,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [lcd_pkg::CFG_DATA_W-1:0] pwdata,
  input logic [lcd_pkg::CFG_DATA_W-1:0] prdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(counter_out) && $stable(last_out))
    else $error("result changed while stalled");

  // reset empties the chain
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // with no result waiting, an item is always taken
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // written period reads back
  a_cfg_readback: assert property (@(posedge clk)
    !rst && psel && penable && pwrite |=> prdata == $past(pwdata))
    else $error("period read back differs from write");

endmodule

bind lfu_counter_decay_core lcd_checker u_lcd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .counter_out (out_ch.counter_out),
  .last_out    (out_ch.last_out),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks lfu counter decay results against a cycle-free predictor, with
// random gaps on the input, random stalls on the output and period changes
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TW = 32;
  // register map: decay period is register 0
  localparam logic [lcd_pkg::CFG_ADDR_W-1:0] REG_DECAY_PERIOD = '0;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 162;
  localparam int PIPE_CYCLES   = 12;
  localparam int CYCLE_LIMIT   = 1000000;

  // one aged counter as it should leave the block
  typedef struct packed {
    logic [lcd_pkg::COUNT_W-1:0] counter;
    logic                        last;
  } aged_t;

  // one directed row; result is only used where known is set
  typedef struct packed {
    logic [lcd_pkg::PERIOD_W-1:0] period;
    logic [TW-1:0]                ts;
    logic [lcd_pkg::COUNT_W-1:0]  cnt;
    logic [TW-1:0]                now;
    logic                         last;
    logic                         known;
    logic [lcd_pkg::COUNT_W-1:0]  result;
  } probe_t;

  localparam logic [TW-1:0] ONES = '1;

  // directed rows: period, timestamp, counter, now, last, known, result
  probe_t probes [21] = '{
    // zero elapsed at both counter extremes
    '{32'd1, 32'd0, 8'd0, 32'd0, 1'b0, 1'b1, 8'd0},
    '{32'd1, 32'd0, 8'd255, 32'd0, 1'b1, 1'b1, 8'd255},
    // sentinel timestamp
    '{32'd1, ONES, 8'd0, 32'd0, 1'b0, 1'b1, 8'd127},
    '{32'd1, ONES, 8'd255, ONES, 1'b1, 1'b1, 8'd127},
    // around the period cap
    '{32'd1, 32'd0, 8'd255, 32'd255, 1'b0, 1'b1, 8'd0},
    '{32'd1, 32'd0, 8'd255, 32'd254, 1'b0, 1'b1, 8'd1},
    '{32'd1, 32'd0, 8'd255, 32'd256, 1'b0, 1'b1, 8'd0},
    // timestamp in the future wraps to a huge elapsed time
    '{32'd1, 32'd10, 8'd50, 32'd5, 1'b0, 1'b1, 8'd0},
    // wrap across zero to a small elapsed time, and a large one with no wrap
    '{32'd1, 32'hFFFF_FFFE, 8'd10, 32'd2, 1'b1, 1'b0, 8'd0},
    '{32'd1, 32'd100, 8'd200, ONES, 1'b0, 1'b1, 8'd0},
    // alternating bit patterns
    '{32'd1, 32'hAAAA_AAAA, 8'h55, 32'h5555_5555, 1'b1, 1'b0, 8'd0},
    '{32'd1, 32'h5555_5555, 8'hAA, 32'hAAAA_AAAA, 1'b0, 1'b0, 8'd0},
    // zero period acts as one
    '{32'd0, 32'd0, 8'd200, 32'd100, 1'b0, 1'b0, 8'd0},
    '{32'd0, ONES, 8'd7, 32'd0, 1'b1, 1'b1, 8'd127},
    '{32'd0, 32'd5, 8'd3, 32'd5, 1'b0, 1'b1, 8'd3},
    // largest period
    '{ONES, 32'd0, 8'd255, 32'hFFFF_FFFE, 1'b0, 1'b1, 8'd255},
    '{ONES, 32'd0, 8'd255, ONES, 1'b0, 1'b0, 8'd0},
    '{ONES, 32'd1, 8'd0, 32'd0, 1'b1, 1'b1, 8'd0},
    // ordinary period
    '{32'd1000, 32'd5000, 8'd30, 32'd12000, 1'b0, 1'b0, 8'd0},
    '{32'd1000, 32'd0, 8'd255, ONES, 1'b1, 1'b1, 8'd0},
    '{32'd1000, 32'd0, 8'd128, 32'd999, 1'b0, 1'b0, 8'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lcd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lcd_pkg::CFG_DATA_W-1:0] pwdata;
  wire  [lcd_pkg::CFG_DATA_W-1:0] prdata;
  wire                            pready;

  lcd_in_if #(.TIME_WIDTH(TW)) in_ch ();
  lcd_out_if                   out_ch ();

  lfu_counter_decay_core #(.TIME_WIDTH(TW)) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // period the block should be using right now
  logic [lcd_pkg::PERIOD_W-1:0] period_now;
  // aged counters still owed by the block, oldest first
  aged_t aged_q [$];
  aged_t head;
  int    errors;
  int    cycles;

  // expected counter after aging by whole elapsed periods
  function automatic logic [lcd_pkg::COUNT_W-1:0] aged_counter(
    logic [TW-1:0] ts, logic [lcd_pkg::COUNT_W-1:0] cnt, logic [TW-1:0] now,
    logic [lcd_pkg::PERIOD_W-1:0] period
  );
    logic [TW-1:0]                elapsed;
    logic [lcd_pkg::PERIOD_W-1:0] div;
    logic [TW-1:0]                periods;
    if (ts == ONES) return lcd_pkg::SENTINEL_COUNTER;
    div = (period == '0) ? 32'd1 : period;
    elapsed = now - ts;                     // wraps modulo 2^32
    periods = elapsed / div;
    if (periods > TW'(lcd_pkg::PERIOD_CAP)) periods = TW'(lcd_pkg::PERIOD_CAP);
    return (periods > TW'(cnt)) ? '0 : cnt - periods[lcd_pkg::COUNT_W-1:0];
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // elapsed time that mostly lands inside the counter's decay range
  function automatic logic [TW-1:0] pick_elapsed(logic [lcd_pkg::PERIOD_W-1:0] period);
    logic [63:0] div;
    logic [63:0] el;
    int          mode;
    div  = (period == '0) ? 64'd1 : 64'(period);
    mode = $urandom_range(0, 9);
    if (mode < 7)
      el = div * $urandom_range(0, 260) + $urandom_range(0, 32'(div - 64'd1));
    else if (mode == 7)
      el = $urandom;
    else if (mode == 8)
      el = div * $urandom_range(250, 4000);
    else
      el = $urandom_range(0, 3);
    return el[TW-1:0];
  endfunction

  // one item on the input channel, after an optional idle gap
  task automatic send_entry(
    input logic [TW-1:0] ts, input logic [lcd_pkg::COUNT_W-1:0] cnt,
    input logic [TW-1:0] now, input logic last, input int gap,
    input logic known, input logic [lcd_pkg::COUNT_W-1:0] result
  );
    aged_t e;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.last_access_time <= ts;
    in_ch.counter_in       <= cnt;
    in_ch.now_time         <= now;
    in_ch.last_in_batch    <= last;
    in_ch.valid            <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // item taken at this edge
    e.counter = known ? result : aged_counter(ts, cnt, now, period_now);
    e.last    = last;
    aged_q.push_back(e);
  endtask

  // stop sending and let every owed result come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (aged_q.size() == 0);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // apb read with check of the returned value
  task automatic period_read(input logic [lcd_pkg::PERIOD_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_DECAY_PERIOD;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("decay_period readback: expected %0h actual %0h", want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // apb write of the decay period, then read it back
  task automatic period_write(input logic [lcd_pkg::PERIOD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DECAY_PERIOD;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register is written at this edge
    period_now = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    period_read(value);
  endtask

  // period for a random phase; the first ones hit the extremes
  function automatic logic [lcd_pkg::PERIOD_W-1:0] phase_period(int ph);
    case (ph)
      0: return ONES;
      1: return '0;
      2: return 32'd1;
      default: begin
        case ($urandom_range(0, 4))
          0: return $urandom_range(2, 16);
          1: return $urandom_range(17, 4096);
          2: return 32'd1 << $urandom_range(0, 31);
          3: return $urandom;
          default: return $urandom_range(1000, 100000);
        endcase
      end
    endcase
  endfunction

  // output side: ready runs, mostly short and now and then long, broken by stalls of random length
  initial begin
    int run;
    int stall;
    out_ch.ready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                        : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker: each result against the oldest owed one
  always @(posedge clk) begin
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (aged_q.size() == 0) begin
        $error("result with none owed: counter_out %0d last_out %0b",
               out_ch.counter_out, out_ch.last_out);
        errors++;
      end else begin
        head = aged_q.pop_front();
        if (out_ch.counter_out !== head.counter) begin
          $error("counter_out: expected %0d actual %0d", head.counter,
                 out_ch.counter_out);
          errors++;
        end
        if (out_ch.last_out !== head.last) begin
          $error("last_out: expected %0b actual %0b", head.last, out_ch.last_out);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [TW-1:0]               now;
    logic [TW-1:0]               ts;
    logic [lcd_pkg::COUNT_W-1:0] cnt;
    int                          sent;
    int                          len;
    int                          r;
    bit                          calm;

    errors     = 0;
    cycles     = 0;
    period_now = lcd_pkg::PERIOD_RESET;
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.last_access_time <= '0;
    in_ch.counter_in       <= '0;
    in_ch.now_time         <= '0;
    in_ch.last_in_batch    <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register comes out of reset at its default
    period_read(lcd_pkg::PERIOD_RESET);

    // directed rows; period changes only once the block is empty
    foreach (probes[i]) begin
      if (probes[i].period !== period_now) begin
        drain();
        period_write(probes[i].period);
      end
      send_entry(probes[i].ts, probes[i].cnt, probes[i].now, probes[i].last,
                 pick_gap(), probes[i].known, probes[i].result);
    end

    // random phases, each with its own period; the drain before every
    // write also holds the sender until the block has nothing owed
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      period_write(phase_period(ph));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: fields unrelated to each other
          send_entry($urandom, 8'($urandom), $urandom, 1'($urandom),
                     pick_gap(), 1'b0, '0);
          sent++;
        end else begin
          // well-formed batch: one current time, last flag on the final entry
          len  = $urandom_range(1, 12);
          now  = $urandom;
          calm = ($urandom_range(0, 4) == 0);
          for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 99);
            if (r < 6)
              ts = ONES;
            else
              ts = now - pick_elapsed(period_now);
            r = $urandom_range(0, 9);
            cnt = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
            send_entry(ts, cnt, now, j == len - 1, calm ? 0 : pick_gap(),
                       1'b0, '0);
            sent++;
          end
        end
      end
    end

    // wait out every owed result, then let the pipeline settle
    drain();
    repeat (4 * PIPE_CYCLES) @(posedge clk);
    if (errors == 0 && aged_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
